FILE: design/rft_pkg.sv
// Shared types and constants for the region flatten translator.
// Holds the beat structs, the op and status codes and the table entry layout.
// No dependencies.
package rft_pkg;

    localparam int RFT_MAX_REGIONS = 64;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_S2F   = 2'd2,
        OP_F2S   = 2'd3
    } t_op;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_BAD_END = 2'd2;

    typedef struct packed {
        t_op         op;
        logic [63:0] addr;
        logic [63:0] region_end;
    } t_in_beat;

    typedef struct packed {
        logic [63:0] result_addr;
        logic        in_region;
        logic [5:0]  region_index;
        logic [1:0]  status;
        logic [6:0]  region_count;
    } t_out_beat;

    // One stored region: sparse start, sparse end and flat start.
    typedef struct packed {
        logic [63:0] ss;
        logic [63:0] se;
        logic [63:0] fs;
    } t_entry;

endpackage

FILE: design/rft_ram.sv
// Generic single write port, single read port RAM with a registered read.
// Used for the region table. No dependencies.
module rft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/region_flatten_translator_unit.sv
// Top level of the region flatten translator: sequencer, region table RAM.
// Depends on rft_pkg and rft_ram.
//
// Channel | Direction | Handshake                  | Payload
// --------+-----------+----------------------------+--------------------------
// in      | input     | i_in_valid / o_in_stall    | i_in_data  (t_in_beat)
// out     | output    | o_out_valid / i_out_stall  | o_out_data (t_out_beat)
//
// One beat is worked on at a time; the input is stalled until its result is
// staged in the output register. A lookup is a binary search over the
// regions, and a sparse miss in a gap adds a linear scan of the regions. An
// add scans down from the last region, moving up each region past the new one.
// Reset is synchronous and empties the table; the RAM itself is not cleared.
// A stalled output holds its beat, and the next beat can be accepted while
// it waits.
module region_flatten_translator_unit
    import rft_pkg::*;
#(
    parameter int MAX_REGIONS = RFT_MAX_REGIONS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_beat  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_beat o_out_data,
    input  logic      i_out_stall
);

    localparam int AW = $clog2(MAX_REGIONS);
    localparam int CW = $clog2(MAX_REGIONS + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RDW,
        S_ADD_CHK,
        S_ADD_INS,
        S_LK_ISSUE,
        S_LK_CMP,
        S_LK_END,
        S_LK_DEC,
        S_LK_HIT,
        S_MS_FIRST,
        S_MS_LAST,
        S_MS_SCAN,
        S_MS_DIST,
        S_FM_LAST,
        S_DONE
    } t_state;

    t_state      r_state;
    t_state      r_after;
    t_op         r_op;
    logic [63:0] r_a;
    logic [63:0] r_e;
    logic [CW-1:0] r_count;
    logic [63:0] r_total;
    logic [CW-1:0] r_lo;
    logic [CW-1:0] r_hi1;
    logic [AW-1:0] r_mid;
    logic [AW-1:0] r_idx;
    logic [CW-1:0] r_jc;
    logic [AW-1:0] r_raddr;
    logic        r_we;
    logic [AW-1:0] r_waddr;
    t_entry      r_wdata;
    t_entry      r_ent;
    t_entry      r_prev;
    logic [63:0] r_sz;
    logic [63:0] r_lim;
    logic [63:0] r_delta;
    logic [63:0] r_dp;
    logic [63:0] r_dn;
    logic [63:0] r_fs;
    logic [63:0] r_res;
    logic        r_hit;
    logic [5:0]  r_ridx;
    logic [1:0]  r_stat;
    logic        r_ovalid;
    t_out_beat   r_out;

    t_entry      w_rd;
    logic [CW:0] w_sum;
    logic [AW-1:0] w_mid;
    logic        w_flat;
    logic [63:0] w_s;

    rft_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MAX_REGIONS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (r_we),
        .i_waddr (r_waddr),
        .i_wdata (r_wdata),
        .i_raddr (r_raddr),
        .o_rdata (w_rd)
    );

    // Midpoint of the open search window [lo, hi1).
    always_comb begin
        w_sum  = {1'b0, r_lo} + {1'b0, r_hi1} - 1'b1;
        w_mid  = AW'(w_sum >> 1);
        w_flat = (r_op == OP_F2S);
        w_s    = w_flat ? r_ent.fs : r_ent.ss;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_after  <= S_IDLE;
            r_count  <= '0;
            r_total  <= '0;
            r_we     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            // The table is written when a region moves up and when the new
            // region is inserted.
            r_we <= (r_state == S_ADD_INS) || ((r_state == S_ADD_CHK) && (w_rd.ss > r_a));
            if (r_state == S_DONE && (!r_ovalid || !i_out_stall)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op   <= i_in_data.op;
                        r_a    <= i_in_data.addr;
                        r_e    <= i_in_data.region_end;
                        r_res  <= '0;
                        r_hit  <= 1'b0;
                        r_ridx <= '0;
                        r_stat <= ST_OK;
                        case (i_in_data.op)
                            OP_CLEAR: begin
                                r_count <= '0;
                                r_total <= '0;
                                r_state <= S_DONE;
                            end
                            OP_ADD: begin
                                if (i_in_data.region_end < i_in_data.addr) begin
                                    r_stat  <= ST_BAD_END;
                                    r_state <= S_DONE;
                                end else if (r_count >= CW'(MAX_REGIONS)) begin
                                    r_stat  <= ST_FULL;
                                    r_state <= S_DONE;
                                end else begin
                                    r_sz <= i_in_data.region_end - i_in_data.addr;
                                    r_fs <= r_total;
                                    if (r_count == '0) begin
                                        r_idx   <= '0;
                                        r_state <= S_ADD_INS;
                                    end else begin
                                        r_idx   <= AW'(r_count - 1'b1);
                                        r_raddr <= AW'(r_count - 1'b1);
                                        r_after <= S_ADD_CHK;
                                        r_state <= S_RDW;
                                    end
                                end
                            end
                            default: begin
                                r_lo    <= '0;
                                r_hi1   <= r_count;
                                r_state <= S_LK_ISSUE;
                            end
                        endcase
                    end
                end
                S_RDW: begin
                    r_state <= r_after;
                end
                // Walk down from the last region, moving each region that
                // starts after the new one up by one slot.
                S_ADD_CHK: begin
                    if (w_rd.ss > r_a) begin
                        r_waddr    <= r_idx + 1'b1;
                        r_wdata.ss <= w_rd.ss;
                        r_wdata.se <= w_rd.se;
                        r_wdata.fs <= w_rd.fs + r_sz;
                        r_fs       <= w_rd.fs;
                        if (r_idx == '0) begin
                            r_state <= S_ADD_INS;
                        end else begin
                            r_idx   <= r_idx - 1'b1;
                            r_raddr <= r_idx - 1'b1;
                            r_after <= S_ADD_CHK;
                            r_state <= S_RDW;
                        end
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_ADD_INS;
                    end
                end
                S_ADD_INS: begin
                    r_waddr    <= r_idx;
                    r_wdata.ss <= r_a;
                    r_wdata.se <= r_e;
                    r_wdata.fs <= r_fs;
                    r_count    <= r_count + 1'b1;
                    r_total    <= r_total + r_sz;
                    r_res      <= r_fs;
                    r_state    <= S_DONE;
                end
                S_LK_ISSUE: begin
                    if (r_lo >= r_hi1) begin
                        if (!w_flat) begin
                            if (r_count == '0) begin
                                r_state <= S_DONE;
                            end else begin
                                r_raddr <= '0;
                                r_after <= S_MS_FIRST;
                                r_state <= S_RDW;
                            end
                        end else if (r_count != '0 && r_a >= r_total) begin
                            r_raddr <= AW'(r_count - 1'b1);
                            r_after <= S_FM_LAST;
                            r_state <= S_RDW;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end else begin
                        r_mid   <= w_mid;
                        r_raddr <= w_mid;
                        r_after <= S_LK_CMP;
                        r_state <= S_RDW;
                    end
                end
                S_LK_CMP: begin
                    r_ent   <= w_rd;
                    r_sz    <= w_rd.se - w_rd.ss;
                    r_state <= S_LK_END;
                end
                S_LK_END: begin
                    r_lim   <= w_flat ? (r_ent.fs + r_sz) : r_ent.se;
                    r_state <= S_LK_DEC;
                end
                S_LK_DEC: begin
                    if (r_a >= w_s && r_a < r_lim) begin
                        r_delta <= r_a - w_s;
                        r_state <= S_LK_HIT;
                    end else if (r_a < w_s) begin
                        r_hi1   <= CW'(r_mid);
                        r_state <= S_LK_ISSUE;
                    end else begin
                        r_lo    <= CW'(r_mid) + 1'b1;
                        r_state <= S_LK_ISSUE;
                    end
                end
                S_LK_HIT: begin
                    r_res   <= (w_flat ? r_ent.ss : r_ent.fs) + r_delta;
                    r_hit   <= 1'b1;
                    r_ridx  <= 6'(r_mid);
                    r_state <= S_DONE;
                end
                S_MS_FIRST: begin
                    if (r_a < w_rd.ss) begin
                        r_state <= S_DONE;
                    end else begin
                        r_prev  <= w_rd;
                        r_raddr <= AW'(r_count - 1'b1);
                        r_after <= S_MS_LAST;
                        r_state <= S_RDW;
                    end
                end
                S_MS_LAST: begin
                    if (r_a >= w_rd.se) begin
                        r_res   <= r_total;
                        r_state <= S_DONE;
                    end else if (r_count < CW'(2)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_jc    <= CW'(1);
                        r_raddr <= AW'(1);
                        r_after <= S_MS_SCAN;
                        r_state <= S_RDW;
                    end
                end
                // Look for the gap between the previous and the current region.
                S_MS_SCAN: begin
                    if (r_a >= r_prev.se && r_a < w_rd.ss) begin
                        r_dp    <= r_a - r_prev.se;
                        r_dn    <= w_rd.ss - r_a;
                        r_sz    <= r_prev.se - r_prev.ss;
                        r_fs    <= w_rd.fs;
                        r_state <= S_MS_DIST;
                    end else begin
                        r_prev <= w_rd;
                        if (r_jc + 1'b1 >= r_count) begin
                            r_state <= S_DONE;
                        end else begin
                            r_jc    <= r_jc + 1'b1;
                            r_raddr <= AW'(r_jc + 1'b1);
                            r_after <= S_MS_SCAN;
                            r_state <= S_RDW;
                        end
                    end
                end
                // Ties go to the start of the next region.
                S_MS_DIST: begin
                    r_res   <= (r_dp < r_dn) ? (r_prev.fs + r_sz) : r_fs;
                    r_state <= S_DONE;
                end
                S_FM_LAST: begin
                    r_res   <= w_rd.se;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ovalid || !i_out_stall) begin
                        r_out.result_addr  <= r_res;
                        r_out.in_region    <= r_hit;
                        r_out.region_index <= r_ridx;
                        r_out.status       <= r_stat;
                        r_out.region_count <= 7'(r_count);
                        r_state            <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

endmodule

FILE: verif/rft_checker.sv
// Checker for the region flatten translator: watches both channels, predicts
// each result beat from its own copy of the region table and compares.
// Depends on rft_pkg.
module rft_checker
    import rft_pkg::*;
#(
    parameter int MAX_REGIONS = RFT_MAX_REGIONS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_beat  i_in_data,
    input  logic      i_in_stall,
    input  logic      i_out_valid,
    input  t_out_beat i_out_data,
    input  logic      i_out_stall,
    output int        o_fail_count,
    output int        o_pending
);

    logic [63:0] sp_start [MAX_REGIONS];
    logic [63:0] sp_end   [MAX_REGIONS];
    logic [63:0] fl_start [MAX_REGIONS];
    int          region_total;
    logic [63:0] flat_sum;
    t_out_beat   awaited_results [$];

    function automatic logic [63:0] flat_end_at(int i);
        return fl_start[i] + (sp_end[i] - sp_start[i]);
    endfunction

    // Binary search over the sorted table; returns -1 on a miss.
    function automatic int find_region(logic [63:0] a, bit flat);
        int lo;
        int hi;
        int mid;
        logic [63:0] s;
        logic [63:0] e;
        lo = 0;
        hi = region_total - 1;
        while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            s = flat ? fl_start[mid] : sp_start[mid];
            e = flat ? flat_end_at(mid) : sp_end[mid];
            if (a >= s && a < e) return mid;
            if (a < s) begin
                if (mid == 0) break;
                hi = mid - 1;
            end else begin
                lo = mid + 1;
            end
        end
        return -1;
    endfunction

    function automatic t_out_beat translate_beat(t_in_beat b);
        t_out_beat r;
        int hit;
        int pos;
        logic [63:0] sz;
        logic [63:0] fs;
        logic [63:0] dp;
        logic [63:0] dn;
        r = '0;
        r.status = ST_OK;
        case (b.op)
            OP_CLEAR: begin
                region_total = 0;
                flat_sum = '0;
            end
            OP_ADD: begin
                if (b.region_end < b.addr) begin
                    r.status = ST_BAD_END;
                end else if (region_total >= MAX_REGIONS) begin
                    r.status = ST_FULL;
                end else begin
                    sz = b.region_end - b.addr;
                    pos = 0;
                    while (pos < region_total && sp_start[pos] <= b.addr) pos++;
                    fs = (pos < region_total) ? fl_start[pos] : flat_sum;
                    for (int i = region_total; i > pos; i--) begin
                        sp_start[i] = sp_start[i-1];
                        sp_end[i] = sp_end[i-1];
                        fl_start[i] = fl_start[i-1] + sz;
                    end
                    sp_start[pos] = b.addr;
                    sp_end[pos] = b.region_end;
                    fl_start[pos] = fs;
                    region_total++;
                    flat_sum += sz;
                    r.result_addr = fs;
                end
            end
            OP_S2F: begin
                hit = find_region(b.addr, 1'b0);
                if (hit >= 0) begin
                    r.result_addr = fl_start[hit] + (b.addr - sp_start[hit]);
                    r.in_region = 1'b1;
                    r.region_index = hit[5:0];
                end else if (region_total == 0 || b.addr < sp_start[0]) begin
                    r.result_addr = '0;
                end else if (b.addr >= sp_end[region_total-1]) begin
                    r.result_addr = flat_sum;
                end else begin
                    for (int i = 0; i + 1 < region_total; i++) begin
                        if (b.addr >= sp_end[i] && b.addr < sp_start[i+1]) begin
                            dp = b.addr - sp_end[i];
                            dn = sp_start[i+1] - b.addr;
                            r.result_addr = (dp < dn) ? flat_end_at(i) : fl_start[i+1];
                            break;
                        end
                    end
                end
            end
            default: begin
                hit = find_region(b.addr, 1'b1);
                if (hit >= 0) begin
                    r.result_addr = sp_start[hit] + (b.addr - fl_start[hit]);
                    r.in_region = 1'b1;
                    r.region_index = hit[5:0];
                end else if (region_total != 0 && b.addr >= flat_sum) begin
                    r.result_addr = sp_end[region_total-1];
                end
            end
        endcase
        r.region_count = region_total[6:0];
        return r;
    endfunction

    assign o_pending = awaited_results.size();

    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            region_total = 0;
            flat_sum = '0;
            awaited_results.delete();
            o_fail_count <= 0;
        end else begin
            if (i_in_valid && !i_in_stall)
                awaited_results = {awaited_results, translate_beat(i_in_data)};
            if (i_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result beat %p", i_out_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = awaited_results.pop_front();
                    if (want !== i_out_data) begin
                        if (o_fail_count < 10)
                            $display("mismatch: expected %p got %p", want, i_out_data);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

FILE: verif/tb_top.sv
// Testbench top for region_flatten_translator_unit: drives stimulus beats,
// applies idle and stall pressure and prints the verdict.
// Depends on rft_pkg, rft_checker and the block itself.
module tb_top
    import rft_pkg::*;
;

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    t_in_beat  in_beat;
    logic      in_stall;
    logic      out_valid;
    t_out_beat out_beat;
    logic      out_stall;
    int        fail_count;
    int        pending;
    int        cycle_count = 0;
    bit        hold_off_req;
    bit        hold_off_done;

    region_flatten_translator_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_data(in_beat), .o_in_stall(in_stall),
        .o_out_valid(out_valid), .o_out_data(out_beat), .i_out_stall(out_stall)
    );

    rft_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_data(in_beat), .i_in_stall(in_stall),
        .i_out_valid(out_valid), .i_out_data(out_beat), .i_out_stall(out_stall),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // A generous watchdog: the longest beat is a sparse miss scanned across a
    // full table, and each beat may also wait out an input gap and a receiver
    // stall.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000) begin
            $display("region_flatten_translator_unit regression: fail");
            $finish;
        end
    end

    // Receiver side: a random stall before each beat, or a long hold-off when
    // the stimulus asks for one so that the block fills and stalls its input.
    initial begin
        int wait_cycles;
        out_stall = 1'b1;
        hold_off_done = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off_req && !hold_off_done) begin
                out_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
                hold_off_done = 1'b1;
            end
            wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            if (wait_cycles > 0) begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge i_clk);
            end
            out_stall <= 1'b0;
            @(posedge i_clk iff out_valid);
        end
    end

    // Hands one beat over and waits until it is accepted.
    task automatic send_beat(t_op op, logic [63:0] a, logic [63:0] e, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_beat <= '{op: op, addr: a, region_end: e};
        @(posedge i_clk iff !in_stall);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk iff pending == 0);
    endtask

    initial begin
        logic [63:0] base;
        logic [63:0] a;
        logic [63:0] e;
        int kind;
        hold_off_req = 1'b0;
        in_valid = 1'b0;
        in_beat = '0;
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: lookups on an empty table, bad ends, empty and overlapping
        // regions, equal starts, gaps and both-way misses.
        send_beat(OP_S2F, '1, 0, 0);
        send_beat(OP_F2S, 0, 0, 0);
        send_beat(OP_ADD, 64'd100, 64'd99, 0);
        send_beat(OP_ADD, '1, 0, 0);
        send_beat(OP_ADD, 64'd100, 64'd110, 0);
        send_beat(OP_ADD, 64'd130, 64'd140, 0);
        send_beat(OP_ADD, 64'd100, 64'd100, 0);
        send_beat(OP_ADD, 64'd105, 64'd135, 0);
        send_beat(OP_ADD, 0, 64'd5, 0);
        send_beat(OP_S2F, 64'd120, 0, 0);
        send_beat(OP_S2F, 64'd3, 0, 0);
        send_beat(OP_S2F, 64'd50, 0, 0);
        send_beat(OP_S2F, 64'd52, 0, 0);
        send_beat(OP_S2F, 64'd107, 0, 0);
        send_beat(OP_S2F, '1, 0, 0);
        send_beat(OP_F2S, 64'd7, 0, 0);
        send_beat(OP_F2S, '1, 0, 0);
        send_beat(OP_ADD, '1, '1, 0);
        send_beat(OP_ADD, 0, '1, 0);
        send_beat(OP_S2F, '1, 0, 0);
        send_beat(OP_F2S, 64'h8000_0000_0000_0000, 0, 0);
        send_beat(OP_CLEAR, '1, '1, 0);
        send_beat(OP_S2F, 64'd5, 0, 0);

        // Pressure: the receiver holds off while beats keep coming.
        hold_off_req = 1'b1;
        for (int i = 0; i < 8; i++) send_beat(OP_ADD, i * 64'd20, i * 64'd20 + 64'd9, 1);
        in_valid <= 1'b0;
        @(posedge i_clk iff hold_off_done);
        drain();

        // Random: mostly clustered tables, with lookups near boundaries; now and
        // then raw 64-bit noise.
        for (int i = 0; i < 1900; i++) begin
            if (i % 150 == 0) base = ($urandom_range(0, 3) == 0) ? rand64() : 0;
            kind = $urandom_range(0, 99);
            a = base + $urandom_range(0, 4000);
            if (kind < 2) begin
                send_beat(OP_CLEAR, rand64(), rand64(), 0);
            end else if (kind < 40) begin
                e = ($urandom_range(0, 15) == 0) ? a - $urandom_range(1, 50)
                                                 : a + $urandom_range(0, 300);
                send_beat(OP_ADD, a, e, 0);
            end else if (kind < 92) begin
                send_beat($urandom_range(0, 1) ? OP_S2F : OP_F2S,
                          (kind & 1) ? a : base + $urandom_range(0, 20000), 0, 0);
            end else begin
                send_beat(t_op'($urandom_range(1, 3)), rand64(), rand64(), 0);
            end
            if (i == 900) drain();
        end
        drain();

        repeat (400) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("region_flatten_translator_unit regression: pass");
        else
            $display("region_flatten_translator_unit regression: fail");
        $finish;
    end

endmodule
